### rtl/core/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types and constants for the differential drive odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int PROD_W    = 68;   // serial multiplier accumulator width
    localparam int MUL_B_W   = 34;   // widest multiplier operand
    localparam int MUL_CNT_W = 6;    // multiplier bit counter
    localparam int ANG_W     = 34;   // CORDIC x/y/z width
    localparam int DIST_W    = 34;   // forward distance, Q.24 meters
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TRACK    = 2'd1;

    localparam logic [15:0] WHEEL_RADIUS_RST = 16'd6554;
    localparam logic [15:0] INV_TRACK_RST    = 16'd5120;

    localparam logic [15:0]       RATE_MUL     = 16'd10937;
    localparam logic [20:0]       DIST_DIVISOR = 21'd2000000;
    localparam logic [PROD_W-1:0] DIST_HALF    = 68'd1000000;
    localparam logic [ANG_W-1:0]  CORDIC_START = 34'd652032874;

    typedef struct packed {
        logic                 start;
        logic                 b_signed;
        logic [MUL_CNT_W-1:0] b_len;
    } ddo_mul_ctl_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/core/ddo_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_mul
    import ddo_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ddo_mul_ctl_t              ctl,
    input  wire logic signed [PROD_W-1:0]  a,
    input  wire logic [MUL_B_W-1:0]        b,
    output logic signed [PROD_W-1:0]       prod,
    output logic                           done
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [MUL_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MUL_CNT_W-1:0]  len_reg;
    logic                  bsig_reg;
    logic [PROD_W-1:0]     m_reg;
    logic [MUL_B_W-1:0]    q_reg;
    logic [PROD_W-1:0]     p_reg;
    logic [PROD_W-1:0]     addend;
    logic                  last;

    assign addend = q_reg[0] ? m_reg : '0;
    assign last   = (cnt_reg == len_reg - MUL_CNT_W'(1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + MUL_CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            m_reg    <= a;
            q_reg    <= b;
            p_reg    <= '0;
            len_reg  <= ctl.b_len;
            bsig_reg <= ctl.b_signed;
        end
        else if (busy_reg)
        begin
            // sign bit of a signed multiplier carries negative weight
            if (last && bsig_reg)
                p_reg <= p_reg - addend;
            else
                p_reg <= p_reg + addend;
            m_reg <= {m_reg[PROD_W-2:0], 1'b0};
            q_reg <= {1'b0, q_reg[MUL_B_W-1:1]};
        end
    end

    assign prod = p_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### rtl/core/ddo_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_div
// Restoring bit-serial floor division by the distance scale constant.
// ----------------------------------------------------------------------------
module ddo_div
    import ddo_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [PROD_W-1:0]  n,
    output logic signed [DIST_W-1:0]       q,
    output logic                           done
);

    localparam int DVD_W = 53;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [20:0]       rem_reg;
    logic [DIST_W-1:0] quo_reg;
    logic [PROD_W-1:0] mag;
    logic [21:0]       trial;
    logic              fits;

    // floor(n/k) for n < 0 equals ~floor(~n/k)
    assign mag   = n[PROD_W-1] ? ~n : n;
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, DIST_DIVISOR});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= n[PROD_W-1];
            dvd_reg <= mag[DVD_W-1:0];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 21'(trial - {1'b0, DIST_DIVISOR}) : trial[20:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIST_W-2:0], fits};
        end
    end

    assign q    = neg_reg ? ~quo_reg : quo_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### rtl/core/ddo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int HEADING_BITS      = 16,
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [HEADING_BITS-1:0] angle,
    output logic signed [ANG_W-1:0]      cos_out,
    output logic signed [ANG_W-1:0]      sin_out,
    output logic                         valid
);

    localparam int CNT_W = $clog2(CORDIC_ITERATIONS + 1);

    logic                    busy_reg, busy_next;
    logic                    valid_reg, valid_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [1:0]              quad_reg;
    logic signed [ANG_W-1:0] x_reg, y_reg, z_reg;
    logic [31:0]             a32;
    logic [31:0]             a_rnd;
    logic [1:0]              quad;
    logic [31:0]             z0;
    logic [4:0]              idx;
    logic signed [ANG_W-1:0] xs, ys, at;

    assign a32   = 32'(angle) << (32 - HEADING_BITS);
    assign a_rnd = a32 + 32'h2000_0000;
    assign quad  = a_rnd[31:30];
    assign z0    = a32 - {quad, 30'd0};
    assign idx   = 5'(cnt_reg);
    assign xs    = x_reg >>> idx;
    assign ys    = y_reg >>> idx;
    assign at    = ANG_W'(atan_lut(idx));

    always_comb
    begin
        busy_next  = busy_reg;
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            valid_next = 1'b0;
            cnt_next   = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(CORDIC_ITERATIONS - 1))
            begin
                busy_next  = 1'b0;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_START;
            y_reg    <= '0;
            z_reg    <= ANG_W'($signed(z0));
            quad_reg <= quad;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ANG_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    // quadrant unfold
    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                cos_out = x_reg;
                sin_out = y_reg;
            end
            2'd1:
            begin
                cos_out = -y_reg;
                sin_out = x_reg;
            end
            2'd2:
            begin
                cos_out = -x_reg;
                sin_out = -y_reg;
            end
            default:
            begin
                cos_out = y_reg;
                sin_out = -x_reg;
            end
        endcase
    end

    assign valid = valid_reg;

endmodule
`default_nettype wire

### rtl/core/differential_drive_odometry_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Dead-reckoning pose integrator for a two-wheeled differential drive.
// Each item runs through eight products on the shared serial multiplier and
//   the serial divider in turn; in_ready is high only in idle, so a new item
//   is not taken before the last one is through. The next item is taken as
//   soon as the sequencer returns to idle, even while the last pose still
//   waits. A pose that is not taken holds the sequencer in its final state.
// Reset: pose and heading clear to zero, config registers to their defaults.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top
    import ddo_pkg::*;
#(
    parameter int HEADING_BITS      = 16,
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    // input item channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [15:0]   left_wheel_speed,
    input  wire logic signed [15:0]   right_wheel_speed,
    input  wire logic [19:0]          elapsed_time,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        pos_x,
    output logic signed [31:0]        pos_y,
    output logic [15:0]               heading
);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;   // (wl + wr) * radius
    localparam logic [3:0] S_M2   = 4'd2;   // * elapsed time
    localparam logic [3:0] S_DIV  = 4'd3;   // round to Q.24 distance
    localparam logic [3:0] S_M3   = 4'd4;   // d * cos
    localparam logic [3:0] S_M4   = 4'd5;   // d * sin
    localparam logic [3:0] S_M5   = 4'd6;   // (wr - wl) * radius
    localparam logic [3:0] S_M6   = 4'd7;   // * inverse track width
    localparam logic [3:0] S_M7   = 4'd8;   // * rate scale
    localparam logic [3:0] S_M8   = 4'd9;   // rate * elapsed time
    localparam logic [3:0] S_DONE = 4'd10;  // wait for the output register

    localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;
    localparam logic [PROD_W-1:0]  RATE_RND = 68'd1 << 23;
    localparam logic [PROD_W-1:0]  POS_RND  = 68'd1 << 37;
    localparam logic [PROD_W-1:0]  HD_RND   = 68'd1 << (47 - HEADING_BITS);

    logic [3:0]  state_reg, state_next;
    logic        launch_reg, launch_next;
    logic        out_valid_reg, out_valid_next;

    logic [15:0] radius_reg;
    logic [15:0] inv_track_reg;

    // accumulated pose, driven straight to the result ports
    logic signed [31:0]      x_acc_reg;
    logic signed [31:0]      y_acc_reg;
    logic [HEADING_BITS-1:0] heading_acc_reg;

    // pose waiting to be committed
    logic signed [31:0]      x_pend_reg;
    logic signed [31:0]      y_pend_reg;
    logic [HEADING_BITS-1:0] h_pend_reg;

    // latched item
    logic signed [15:0] wl_reg;
    logic signed [15:0] wr_reg;
    logic [19:0]        dt_reg;

    logic in_xfer;
    logic commit;

    // shared serial multiplier
    ddo_mul_ctl_t              mul_ctl;
    logic signed [PROD_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]  mul_prod;
    logic                      mul_done;

    // distance divider
    logic                      div_start;
    logic signed [DIST_W-1:0]  fwd_dist;
    logic                      div_done;

    // sine/cosine
    logic signed [ANG_W-1:0]   cos_v;
    logic signed [ANG_W-1:0]   sin_v;
    logic                      cs_valid;

    logic signed [16:0]        w_sum;
    logic signed [16:0]        w_diff;
    logic [PROD_W-1:0]         rate_sum;
    logic [PROD_W-1:0]         pos_sum;
    logic [PROD_W-1:0]         hd_sum;
    logic signed [33:0]        acc_sum;
    logic signed [31:0]        acc_sat;
    logic signed [31:0]        acc_cur;
    logic                      mul_go;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign commit    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign w_sum  = 17'(wl_reg) + 17'(wr_reg);
    assign w_diff = 17'(wr_reg) - 17'(wl_reg);

    // round-half-up helpers on the product
    assign rate_sum = mul_prod + RATE_RND;
    assign pos_sum  = mul_prod + POS_RND;
    assign hd_sum   = mul_prod + HD_RND;

    // saturating position update, shared by the x and y products
    assign acc_cur = (state_reg == S_M3) ? x_acc_reg : y_acc_reg;
    assign acc_sum = 34'(acc_cur) + 34'($signed(pos_sum[PROD_W-1:38]));
    always_comb
    begin
        priority if (acc_sum > SAT_MAX)
            acc_sat = 32'(SAT_MAX);
        else if (acc_sum < SAT_MIN)
            acc_sat = 32'(SAT_MIN);
        else
            acc_sat = acc_sum[31:0];
    end

    // the x product waits for sine/cosine to settle
    assign mul_go = launch_reg &&
                    (state_reg == S_M1 || state_reg == S_M2 || state_reg == S_M4 ||
                     state_reg == S_M5 || state_reg == S_M6 || state_reg == S_M7 ||
                     state_reg == S_M8 || (state_reg == S_M3 && cs_valid));
    assign div_start = launch_reg && (state_reg == S_DIV);

    // multiplier operand selection
    always_comb
    begin
        mul_ctl.start    = mul_go;
        mul_ctl.b_signed = 1'b0;
        mul_ctl.b_len    = MUL_CNT_W'(16);
        mul_a            = mul_prod;
        mul_b            = MUL_B_W'(radius_reg);
        unique case (state_reg)
            S_M1:
            begin
                mul_a = PROD_W'(w_sum);
            end
            S_M2:
            begin
                mul_b         = MUL_B_W'(dt_reg);
                mul_ctl.b_len = MUL_CNT_W'(20);
            end
            S_M3:
            begin
                mul_a            = PROD_W'(fwd_dist);
                mul_b            = cos_v;
                mul_ctl.b_signed = 1'b1;
                mul_ctl.b_len    = MUL_CNT_W'(MUL_B_W);
            end
            S_M4:
            begin
                mul_a            = PROD_W'(fwd_dist);
                mul_b            = sin_v;
                mul_ctl.b_signed = 1'b1;
                mul_ctl.b_len    = MUL_CNT_W'(MUL_B_W);
            end
            S_M5:
            begin
                mul_a = PROD_W'(w_diff);
            end
            S_M6:
            begin
                mul_b = MUL_B_W'(inv_track_reg);
            end
            S_M7:
            begin
                mul_b = MUL_B_W'(RATE_MUL);
            end
            S_M8:
            begin
                mul_a         = PROD_W'($signed(rate_sum[63:24]));
                mul_b         = MUL_B_W'(dt_reg);
                mul_ctl.b_len = MUL_CNT_W'(20);
            end
            default:
            begin
                mul_a = mul_prod;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        launch_next    = launch_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (mul_go || div_start)
            launch_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next  = S_M1;
                    launch_next = 1'b1;
                end
            end
            S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7:
            begin
                if (mul_done)
                begin
                    state_next  = (state_reg == S_M2) ? S_DIV : state_reg + 4'd1;
                    launch_next = 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next  = S_M3;
                    launch_next = 1'b1;
                end
            end
            S_M8:
            begin
                if (mul_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            launch_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            radius_reg      <= WHEEL_RADIUS_RST;
            inv_track_reg   <= INV_TRACK_RST;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            heading_acc_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WHEEL_RADIUS)
                    radius_reg <= cfg_data;
                else if (cfg_index == CFG_INV_TRACK)
                    inv_track_reg <= cfg_data;
            end
            if (commit)
            begin
                x_acc_reg       <= x_pend_reg;
                y_acc_reg       <= y_pend_reg;
                heading_acc_reg <= h_pend_reg;
            end
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            wl_reg <= left_wheel_speed;
            wr_reg <= right_wheel_speed;
            dt_reg <= elapsed_time;
        end
        if (mul_done && state_reg == S_M3)
            x_pend_reg <= acc_sat;
        if (mul_done && state_reg == S_M4)
            y_pend_reg <= acc_sat;
        if (mul_done && state_reg == S_M8)
            h_pend_reg <= heading_acc_reg + hd_sum[48-HEADING_BITS +: HEADING_BITS];
    end

    ddo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    ddo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     ($signed(mul_prod + DIST_HALF)),
        .q     (fwd_dist),
        .done  (div_done)
    );

    // uses the heading from before this update
    ddo_cordic #(
        .HEADING_BITS      (HEADING_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_xfer),
        .angle   (heading_acc_reg),
        .cos_out (cos_v),
        .sin_out (sin_v),
        .valid   (cs_valid)
    );

    assign out_valid = out_valid_reg;
    assign pos_x     = x_acc_reg;
    assign pos_y     = y_acc_reg;

    // top 16 bits of the binary angle
    generate
        if (HEADING_BITS >= 16)
        begin : g_hd_wide
            assign heading = heading_acc_reg[HEADING_BITS-1 -: 16];
        end
        else
        begin : g_hd_narrow
            assign heading = 16'(heading_acc_reg) << (16 - HEADING_BITS);
        end
    endgenerate

endmodule
`default_nettype wire

### dv/differential_drive_odometry_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_top_tb
// Drives wheel speed / elapsed time transfers into the odometry core and
// checks every pose transfer against a bit-exact pose integrator kept in
// the bench. Directed table first, then random traffic in several config
// phases, with random gaps and back-pressure on both sides.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top_tb;
    import ddo_pkg::*;

    localparam int HBITS     = 16;
    localparam int CITER     = 16;
    localparam int N_RANDOM  = 430;
    localparam int LIMIT_CYC = 2000000;
    localparam int DRAIN_CYC = 400;

    // index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct {
        logic signed [15:0] wl;
        logic signed [15:0] wr;
        logic [19:0]        dt;
        logic               has_pose;   // typed-in pose to check
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        hd;
    } drive_row_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        hd;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] left_wheel_speed = '0;
    logic signed [15:0] right_wheel_speed = '0;
    logic [19:0] elapsed_time = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0] heading;

    always #5 clk = ~clk;

    differential_drive_odometry_top #(
        .HEADING_BITS      (HBITS),
        .CORDIC_ITERATIONS (CITER)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .left_wheel_speed  (left_wheel_speed),
        .right_wheel_speed (right_wheel_speed),
        .elapsed_time      (elapsed_time),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .heading           (heading)
    );

    // ------------------------------------------------------------------
    // Bench copy of the pose integrator state and config.
    // ------------------------------------------------------------------
    logic [15:0]        radius_q;
    logic [15:0]        inv_track_q;
    longint             x_pos;
    longint             y_pos;
    logic [HBITS-1:0]   hdg_acc;

    pose_t pending_poses[$];
    int    mismatches = 0;
    int    cycles = 0;
    int    out_wait = 0;
    bit    hold_out = 1'b0;    // no back-pressure in the final drain

    // atan(2^-i) in 2^-32 turn
    localparam longint ATAN_TURN[32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1, 1, 0};

    // floor(v / 2^s) with round-half-up
    function automatic longint shr_rnd(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint div_rnd(longint a, longint b);
        longint n;
        longint q;
        n = a + b / 2;
        q = n / b;
        if ((n % b) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // quadrant fold, then CORDIC rotation; cos/sin in Q1.30
    task automatic heading_sincos(input logic [HBITS-1:0] ang,
                                  output longint c, output longint s);
        longint a32;
        longint q;
        longint z;
        longint xc;
        longint yc;
        longint xs;
        longint ys;
        a32 = longint'(ang) << (32 - HBITS);
        q = ((a32 + 64'sh2000_0000) >> 30) & 3;
        z = a32 - q * 64'sh4000_0000;
        xc = 652032874;
        yc = 0;
        if (z >= 64'sh8000_0000)
            z = z - 64'sh1_0000_0000;
        for (int i = 0; i < CITER && i < 32; i++)
        begin
            xs = xc >>> i;
            ys = yc >>> i;
            if (z >= 0)
            begin
                xc = xc - ys; yc = yc + xs; z = z - ATAN_TURN[i];
            end
            else
            begin
                xc = xc + ys; yc = yc - xs; z = z + ATAN_TURN[i];
            end
        end
        case (q)
            0:
            begin
                c = xc;  s = yc;
            end
            1:
            begin
                c = -yc; s = xc;
            end
            2:
            begin
                c = -xc; s = -yc;
            end
            default:
            begin
                c = yc; s = -xc;
            end
        endcase
    endtask

    task automatic integrate_pose(input logic signed [15:0] wl,
                                  input logic signed [15:0] wr,
                                  input logic [19:0] dt,
                                  output pose_t p);
        longint fwd;
        longint c;
        longint s;
        longint w;
        longint rate;
        longint dh;
        fwd = div_rnd((longint'(wl) + longint'(wr)) * longint'(radius_q)
                      * longint'(dt), 2000000);
        heading_sincos(hdg_acc, c, s);
        x_pos = clamp32(x_pos + shr_rnd(fwd * c, 38));
        y_pos = clamp32(y_pos + shr_rnd(fwd * s, 38));
        w = (longint'(wr) - longint'(wl)) * longint'(radius_q)
            * longint'(inv_track_q);
        rate = shr_rnd(w * 10937, 24);
        dh = shr_rnd(rate * longint'(dt), 48 - HBITS);
        hdg_acc = hdg_acc + dh[HBITS-1:0];
        p.px = x_pos[31:0];
        p.py = y_pos[31:0];
        p.hd = hdg_acc[HBITS-1 -: 16];
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic wait_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // valid stays up between back-to-back transfers; dropped only for a gap
    task automatic send_drive(logic signed [15:0] wl, logic signed [15:0] wr,
                              logic [19:0] dt);
        pose_t p;
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            wait_cycles(gap);
        end
        in_valid <= 1'b1;
        left_wheel_speed <= wl;
        right_wheel_speed <= wr;
        elapsed_time <= dt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        integrate_pose(wl, wr, dt, p);
        pending_poses.push_back(p);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_WHEEL_RADIUS)
            radius_q = val;
        else if (idx == CFG_INV_TRACK)
            inv_track_q = val;
        @(posedge clk);
    endtask

    // idle between phases: drain poses, then let the core settle
    task automatic settle;
        in_valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        wait_cycles(DRAIN_CYC);
    endtask

    // mostly modest speeds and short steps, some full-range ones
    task automatic random_drive;
        logic signed [15:0] wl;
        logic signed [15:0] wr;
        logic [19:0] dt;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                wl = $urandom; wr = $urandom; dt = $urandom;
            end
            2:
            begin
                wl = $urandom; wr = wl; dt = $urandom_range(0, 200000);
            end
            3:
            begin
                wl = $urandom; wr = -wl; dt = $urandom_range(0, 200000);
            end
            default:
            begin
                wl = $urandom_range(0, 4096) - 2048;
                wr = $urandom_range(0, 4096) - 2048;
                dt = $urandom_range(0, 100000);
            end
        endcase
        send_drive(wl, wr, dt);
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready wait after each transfer, in-order compare
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                out_wait = hold_out ? 0 : $urandom_range(0, 4);
            else if (out_valid && out_wait > 0)
                out_wait--;
            out_ready <= (out_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pose transfer x=%0d y=%0d h=%0d",
                             pos_x, pos_y, heading);
            end
            else
            begin
                e = pending_poses.pop_front();
                if (pos_x !== e.px || pos_y !== e.py || heading !== e.hd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pose mismatch: exp x=%0d y=%0d h=%0d, ",
                                  "got x=%0d y=%0d h=%0d"},
                                 e.px, e.py, e.hd, pos_x, pos_y, heading);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYC)
        begin
            $display("differential_drive_odometry_top_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table: zero step, extremes, straight runs, spins, wraps.
    // Typed poses only where obvious from reset state.
    // ------------------------------------------------------------------
    drive_row_t dir_rows[] = '{
        '{16'sd0,      16'sd0,      20'd0,       1'b1, 32'sd0, 32'sd0, 16'd0},
        '{16'sd256,    16'sd256,    20'd0,       1'b1, 32'sd0, 32'sd0, 16'd0},
        '{16'sd0,      16'sd0,      20'hFFFFF,   1'b1, 32'sd0, 32'sd0, 16'd0},
        '{16'sd256,    16'sd256,    20'd1000000, 1'b0, 32'sd0, 32'sd0, 16'd0},
        '{-16'sd32768, -16'sd32768, 20'hFFFFF,   1'b0, 32'sd0, 32'sd0, 16'd0},
        '{16'sd32767,  16'sd32767,  20'hFFFFF,   1'b0, 32'sd0, 32'sd0, 16'd0},
        '{-16'sd32768, 16'sd32767,  20'hFFFFF,   1'b0, 32'sd0, 32'sd0, 16'd0},
        '{16'sd32767,  -16'sd32768, 20'hFFFFF,   1'b0, 32'sd0, 32'sd0, 16'd0},
        '{16'sd512,    16'sd1024,   20'd50000,   1'b0, 32'sd0, 32'sd0, 16'd0},
        '{16'sd1024,   16'sd512,    20'd50000,   1'b0, 32'sd0, 32'sd0, 16'd0},
        '{16'sd300,    -16'sd300,   20'd123456,  1'b0, 32'sd0, 32'sd0, 16'd0},
        '{16'sd32767,  16'sd32767,  20'hFFFFF,   1'b0, 32'sd0, 32'sd0, 16'd0},
        '{16'sd5000,   16'sd5100,   20'd1,       1'b0, 32'sd0, 32'sd0, 16'd0},
        '{16'sd0,      16'sd0,      20'd0,       1'b0, 32'sd0, 32'sd0, 16'd0}
    };

    initial
    begin
        pose_t e;
        radius_q = WHEEL_RADIUS_RST;
        inv_track_q = INV_TRACK_RST;
        x_pos = 0;
        y_pos = 0;
        hdg_acc = '0;
        wait_cycles(4);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_drive(dir_rows[i].wl, dir_rows[i].wr, dir_rows[i].dt);
            if (dir_rows[i].has_pose)
            begin
                e = pending_poses[pending_poses.size() - 1];
                if (e.px !== dir_rows[i].px || e.py !== dir_rows[i].py ||
                    e.hd !== dir_rows[i].hd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: typed pose differs from predicted", i);
                end
            end
        end
        settle();

        // max radius and track: pushes position into saturation fast
        write_cfg(CFG_WHEEL_RADIUS, 16'hFFFF);
        write_cfg(CFG_INV_TRACK, 16'hFFFF);
        for (int i = 0; i < 40; i++)
            send_drive(16'sd32767, 16'sd32767, 20'hFFFFF);
        for (int i = 0; i < 40; i++)
            send_drive(-16'sd32768, -16'sd32768, 20'hFFFFF);
        for (int i = 0; i < 20; i++)
            random_drive();
        settle();

        // zero radius: nothing moves; out-of-range index ignored
        write_cfg(CFG_WHEEL_RADIUS, 16'h0000);
        write_cfg(CFG_INV_TRACK, 16'h0000);
        write_cfg(CFG_IDX_SPARE, 16'hA5A5);
        for (int i = 0; i < 10; i++)
            random_drive();
        settle();

        // random phases with random config
        for (int ph = 0; ph < 5; ph++)
        begin
            write_cfg(CFG_WHEEL_RADIUS, ph == 0 ? WHEEL_RADIUS_RST : 16'($urandom));
            write_cfg(CFG_INV_TRACK, ph == 0 ? INV_TRACK_RST : 16'($urandom));
            for (int i = 0; i < N_RANDOM / 5; i++)
                random_drive();
            settle();
        end

        hold_out = 1'b1;
        settle();
        if (mismatches == 0 && pending_poses.size() == 0)
            $display("differential_drive_odometry_top_tb: done, clean");
        else
            $display("differential_drive_odometry_top_tb: done, errors");
        $finish;
    end

endmodule
